/* hw/rtl/cbpi_pkg.sv */
`timescale 1ns / 1ps

package cbpi_pkg;

	// Coordinate width; the binary point passes through the weighted sums unchanged.
	localparam int CW         = 32;
	localparam int MAX_INSERT = 30;
	localparam int IBW        = 5;

	// Largest number of samples on one segment.
	localparam int NMAX = MAX_INSERT + 1;
	// Width of the segment length n and of the sample index j.
	localparam int NBW  = $clog2(NMAX + 1);
	// Width of a cube of values up to 2*NMAX; every weight and 6*n^3 fits in it.
	localparam int CF   = $clog2(8 * NMAX * NMAX * NMAX + 1);
	// Index width of the cube table.
	localparam int TIW  = $clog2(2 * NMAX + 1);
	// Node width: mirrored nodes need two more bits than a coordinate.
	localparam int EW   = CW + 2;
	// Product and accumulator widths.
	localparam int PW   = EW + CF + 1;
	localparam int ACW  = PW + 2;
	// Numerator of the rounding division, and quotient bits the divider resolves.
	localparam int NW   = ACW + 2;
	localparam int QW   = EW + 1;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic [IBW-1:0]       insert_count;
		logic                 final_point;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0] curve_x;
		logic signed [CW-1:0] curve_y;
		logic                 run_end;
		logic                 curve_end;
	} out_t;

	typedef struct packed {
		logic [CF-1:0] c0;
		logic [CF-1:0] c1;
		logic [CF-1:0] c2;
		logic [CF-1:0] c3;
		logic [CF-1:0] d;
	} weights_t;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} mac_ctrl_t;

	typedef logic [CF-1:0] cube_tbl_t [0:2*NMAX];

	function automatic cube_tbl_t build_cube();
		cube_tbl_t t;
		for (int i = 0; i <= 2 * NMAX; i++) begin
			t[i] = CF'(i * i * i);
		end
		return t;
	endfunction

	localparam cube_tbl_t CUBE_TBL = build_cube();

endpackage

/* hw/rtl/cbpi_weights.sv */
`timescale 1ns / 1ps

module cbpi_weights import cbpi_pkg::*; (
	input  logic           clk,
	input  logic           load,
	input  logic [NBW-1:0] n,
	input  logic [NBW-1:0] j,
	output weights_t       w
);

	logic [NBW-1:0] u;
	logic [TIW-1:0] nu_idx;
	logic [TIW-1:0] nj_idx;
	logic [CF-1:0]  cube_u;
	logic [CF-1:0]  cube_j;
	logic [CF-1:0]  cube_n;
	logic [CF+1:0]  c1_full;
	logic [CF+1:0]  c2_full;
	logic [CF+1:0]  d_full;
	weights_t       w_d;

	// With u = n - j the cubic basis weights are u^3, (n+u)^3 - 4u^3,
	// (n+j)^3 - 4j^3 and j^3, over a common denominator of 6n^3.
	always_comb begin
		u       = n - j;
		nu_idx  = TIW'(n) + TIW'(u);
		nj_idx  = TIW'(n) + TIW'(j);
		cube_u  = CUBE_TBL[TIW'(u)];
		cube_j  = CUBE_TBL[TIW'(j)];
		cube_n  = CUBE_TBL[TIW'(n)];
		c1_full = (CF+2)'(CUBE_TBL[nu_idx]) - {cube_u, 2'b00};
		c2_full = (CF+2)'(CUBE_TBL[nj_idx]) - {cube_j, 2'b00};
		d_full  = {cube_n, 2'b00} + {1'b0, cube_n, 1'b0};
		w_d.c0  = cube_u;
		w_d.c1  = c1_full[CF-1:0];
		w_d.c2  = c2_full[CF-1:0];
		w_d.c3  = cube_j;
		w_d.d   = d_full[CF-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			w <= w_d;
		end
	end

endmodule

/* hw/rtl/cbpi_mac.sv */
`timescale 1ns / 1ps

module cbpi_mac import cbpi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mac_ctrl_t             ctrl,
	input  logic [CF-1:0]         coef,
	input  logic signed [EW-1:0]  node,
	output logic signed [ACW-1:0] acc
);

	logic signed [PW-1:0]  prod_q;
	logic signed [ACW-1:0] acc_q;

	assign acc = acc_q;

	// The product is registered and added to the accumulator in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			acc_q  <= '0;
		end else begin
			if (ctrl.mul_en) begin
				prod_q <= node * $signed({1'b0, coef});
			end
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (ctrl.acc_en) begin
				acc_q <= acc_q + ACW'(prod_q);
			end
		end
	end

endmodule

/* hw/rtl/cbpi_div.sv */
`timescale 1ns / 1ps

module cbpi_div import cbpi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [ACW-1:0] acc,
	input  logic [CF-1:0]         d,
	output logic                  done,
	output logic signed [CW-1:0]  res
);

	typedef enum logic [1:0] {
		D_IDLE,
		D_PREP,
		D_RUN,
		D_DONE
	} dstate_t;

	localparam int CNTW = $clog2(QW + 1);
	localparam logic signed [QW:0] SAT_HI = $signed({{(QW + 2 - CW){1'b0}}, {(CW - 1){1'b1}}});
	localparam logic signed [QW:0] SAT_LO = ~SAT_HI;

	dstate_t              st_q;
	logic [CF:0]          den_q;
	logic [CF:0]          rem_q;
	logic [QW-1:0]        lo_q;
	logic [QW-1:0]        quo_q;
	logic                 neg_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 done_q;
	logic signed [CW-1:0] res_q;

	logic signed [NW-1:0] num;
	logic [NW-1:0]        mag;
	logic [CF+1:0]        trial;
	logic                 fits;
	logic signed [QW:0]   qs;

	assign done = done_q;
	assign res  = res_q;

	// The rounded sample is floor((2S + d) / 2d). A negative numerator is
	// turned into a magnitude that gives the floor after negation.
	always_comb begin
		num   = (NW'(acc) <<< 1) + $signed(NW'({1'b0, d}));
		mag   = num[NW-1] ? (NW'({d, 1'b0}) + ~num) : num;
		trial = {rem_q, lo_q[QW-1]};
		fits  = trial >= (CF+2)'(den_q);
		qs    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			den_q  <= '0;
			rem_q  <= '0;
			lo_q   <= '0;
			quo_q  <= '0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						st_q <= D_PREP;
					end
				end
				D_PREP: begin
					den_q <= {d, 1'b0};
					neg_q <= num[NW-1];
					// The high part is below the divisor since the quotient fits QW bits.
					rem_q <= mag[QW+CF:QW];
					lo_q  <= mag[QW-1:0];
					quo_q <= '0;
					cnt_q <= CNTW'(QW);
					st_q  <= D_RUN;
				end
				D_RUN: begin
					if (fits) begin
						rem_q <= (CF+1)'(trial - (CF+2)'(den_q));
					end else begin
						rem_q <= trial[CF:0];
					end
					lo_q  <= lo_q << 1;
					quo_q <= {quo_q[QW-2:0], fits};
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						st_q <= D_DONE;
					end
				end
				D_DONE: begin
					if (qs > SAT_HI) begin
						res_q <= SAT_HI[CW-1:0];
					end else if (qs < SAT_LO) begin
						res_q <= SAT_LO[CW-1:0];
					end else begin
						res_q <= qs[CW-1:0];
					end
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: begin
					st_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/cubic_bspline_point_inserter.sv */
`timescale 1ns / 1ps

// Uniform cubic B-spline point inserter.
// Control points enter on in_item (valid/ready); curve samples leave on
// out_item (valid/ready). Each point is held until three are known; each
// completed segment then yields insert_count+1 samples, and the final point
// flushes the last segments plus the end sample. run_end marks the last
// sample caused by an item, curve_end the last sample of the curve.
// A point that yields no sample only moves the history. Each sample takes,
// per coordinate, a four-product multiply-accumulate and then
// a 35-step restoring division for the rounding, both units shared by x and
// y. An item that yields samples keeps in_ready low until its last one is loaded.
// The output register lets the last sample of an item wait while the next
// item is taken; a stalled receiver holds the sequencer at the point where
// a new sample would be written, with no sample lost.
// Reset clears the point history, so the next point starts a new curve;
// the same happens after each final point.
module cubic_bspline_point_inserter import cbpi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_MAC,
		S_WAIT,
		S_EMIT
	} state_t;

	typedef logic [3:0][EW-1:0] nodes_t;

	state_t               st_q;
	logic signed [CW-1:0] rx_q [3];
	logic signed [CW-1:0] ry_q [3];
	logic [IBW-1:0]       pc_q [2];
	logic [1:0]           seen_q;
	logic signed [CW-1:0] px_q;
	logic signed [CW-1:0] py_q;
	logic [IBW-1:0]       ins_q;
	logic                 fin_q;
	logic                 seg_q;
	logic [NBW-1:0]       n_q;
	logic [NBW-1:0]       j_q;
	logic [NBW-1:0]       jl_q;
	logic                 coord_q;
	logic [2:0]           k_q;
	logic signed [CW-1:0] resx_q;
	logic signed [CW-1:0] resy_q;
	logic                 out_valid_q;
	out_t                 out_q;

	weights_t              w;
	mac_ctrl_t             mac_ctrl;
	logic [CF-1:0]         coef;
	logic signed [EW-1:0]  node;
	logic signed [ACW-1:0] acc;
	logic                  div_start;
	logic                  div_done;
	logic signed [CW-1:0]  div_res;
	nodes_t                nx;
	nodes_t                ny;
	logic [IBW-1:0]        ins_sat;
	logic                  last_sample;
	logic                  out_load;

	function automatic logic [EW-1:0] mirror(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		mirror = (EW'(a) <<< 1) - EW'(b);
	endfunction

	// Nodes of the current segment; the ends are extended by mirroring.
	function automatic nodes_t sel_nodes(input logic signed [CW-1:0] r0,
		input logic signed [CW-1:0] r1, input logic signed [CW-1:0] r2,
		input logic signed [CW-1:0] p, input logic [1:0] seen, input logic seg);
		nodes_t e;
		if (!seg) begin
			e[0] = (seen == 2'd3) ? EW'(r0) : mirror(r1, r2);
			e[1] = EW'(r1);
			e[2] = EW'(r2);
			e[3] = EW'(p);
		end else if (seen == 2'd0) begin
			e[0] = EW'(p);
			e[1] = EW'(p);
			e[2] = EW'(p);
			e[3] = EW'(p);
		end else begin
			e[0] = (seen == 2'd1) ? mirror(r2, p) : EW'(r1);
			e[1] = EW'(r2);
			e[2] = EW'(p);
			e[3] = mirror(p, r2);
		end
		return e;
	endfunction

	cbpi_weights u_weights (
		.clk  (clk),
		.load (st_q == S_SETUP),
		.n    (n_q),
		.j    (j_q),
		.w    (w)
	);

	cbpi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   (coef),
		.node   (node),
		.acc    (acc)
	);

	cbpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc),
		.d      (w.d),
		.done   (div_done),
		.res    (div_res)
	);

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		ins_sat = (in_item.insert_count > IBW'(MAX_INSERT)) ? IBW'(MAX_INSERT)
			: in_item.insert_count;
		nx = sel_nodes(rx_q[0], rx_q[1], rx_q[2], px_q, seen_q, seg_q);
		ny = sel_nodes(ry_q[0], ry_q[1], ry_q[2], py_q, seen_q, seg_q);
		case (k_q[1:0])
			2'd0:    coef = w.c0;
			2'd1:    coef = w.c1;
			2'd2:    coef = w.c2;
			default: coef = w.c3;
		endcase
		node = coord_q ? $signed(ny[k_q[1:0]]) : $signed(nx[k_q[1:0]]);
		mac_ctrl.clr    = (st_q == S_SETUP) || (st_q == S_WAIT && div_done && !coord_q);
		mac_ctrl.mul_en = (st_q == S_MAC) && (k_q != 3'd4);
		mac_ctrl.acc_en = (st_q == S_MAC) && (k_q != 3'd0);
		div_start       = (st_q == S_MAC) && (k_q == 3'd4);
		last_sample     = (j_q == jl_q) && (seg_q || !fin_q);
		out_load        = (st_q == S_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			rx_q        <= '{default: '0};
			ry_q        <= '{default: '0};
			pc_q        <= '{default: '0};
			seen_q      <= '0;
			px_q        <= '0;
			py_q        <= '0;
			ins_q       <= '0;
			fin_q       <= 1'b0;
			seg_q       <= 1'b0;
			n_q         <= '0;
			j_q         <= '0;
			jl_q        <= '0;
			coord_q     <= 1'b0;
			k_q         <= '0;
			resx_q      <= '0;
			resy_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q  <= in_item.point_x;
						py_q  <= in_item.point_y;
						ins_q <= ins_sat;
						fin_q <= in_item.final_point;
						j_q   <= '0;
						if (seen_q >= 2'd2) begin
							seg_q <= 1'b0;
							n_q   <= NBW'(pc_q[0]) + NBW'(1);
							jl_q  <= NBW'(pc_q[0]);
							st_q  <= S_SETUP;
						end else if (in_item.final_point) begin
							seg_q <= 1'b1;
							if (seen_q == 2'd0) begin
								n_q  <= NBW'(1);
								jl_q <= '0;
							end else begin
								n_q  <= NBW'(pc_q[1]) + NBW'(1);
								jl_q <= NBW'(pc_q[1]) + NBW'(1);
							end
							st_q <= S_SETUP;
						end else begin
							// Too few points for a segment: only the history moves.
							rx_q   <= '{rx_q[1], rx_q[2], in_item.point_x};
							ry_q   <= '{ry_q[1], ry_q[2], in_item.point_y};
							pc_q   <= '{pc_q[1], ins_sat};
							seen_q <= seen_q + 2'd1;
						end
					end
				end
				S_SETUP: begin
					coord_q <= 1'b0;
					k_q     <= '0;
					st_q    <= S_MAC;
				end
				S_MAC: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (div_done) begin
						if (!coord_q) begin
							resx_q  <= div_res;
							coord_q <= 1'b1;
							k_q     <= '0;
							st_q    <= S_MAC;
						end else begin
							resy_q <= div_res;
							st_q   <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_load) begin
						out_q.curve_x   <= resx_q;
						out_q.curve_y   <= resy_q;
						out_q.run_end   <= last_sample;
						out_q.curve_end <= last_sample && fin_q;
						if (last_sample) begin
							if (fin_q) begin
								rx_q   <= '{default: '0};
								ry_q   <= '{default: '0};
								pc_q   <= '{default: '0};
								seen_q <= '0;
							end else begin
								rx_q   <= '{rx_q[1], rx_q[2], px_q};
								ry_q   <= '{ry_q[1], ry_q[2], py_q};
								pc_q   <= '{pc_q[1], ins_q};
								seen_q <= (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
							end
							st_q <= S_IDLE;
						end else if (j_q == jl_q) begin
							// Move on to the closing segment of the curve.
							seg_q <= 1'b1;
							j_q   <= '0;
							n_q   <= NBW'(pc_q[1]) + NBW'(1);
							jl_q  <= NBW'(pc_q[1]) + NBW'(1);
							st_q  <= S_SETUP;
						end else begin
							j_q  <= j_q + NBW'(1);
							st_q <= S_SETUP;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/cbpi_checker.sv */
`timescale 1ns / 1ps

module cbpi_checker import cbpi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_item,
	input logic out_valid,
	input logic out_ready,
	input out_t out_item
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without handshake");

	// The end of the curve is always the end of the item's run.
	a_curve_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.curve_end |-> out_item.run_end)
		else $error("curve end without run end");

	// A final point always yields samples, so the block is busy after it.
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.final_point |=> !in_ready)
		else $error("ready right after a final point");

endmodule

bind cubic_bspline_point_inserter cbpi_checker u_cbpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

class spline_scoreboard;
	cbpi_pkg::out_t samples_due[$];
	int errors;
	int samples_checked;
	longint hist_x[3];
	longint hist_y[3];
	int held_counts[2];
	int points_held;

	function new();
		errors = 0;
		samples_checked = 0;
		clear_curve();
	endfunction

	function void clear_curve();
		for (int i = 0; i < 3; i++) begin
			hist_x[i] = 0;
			hist_y[i] = 0;
		end
		held_counts[0] = 0;
		held_counts[1] = 0;
		points_held = 0;
	endfunction

	function longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	// Exact weighted sum at t = j/n, then rounded and saturated; the magnitudes stay well inside 64 bits.
	function longint blend(longint e[4], longint n, longint j);
		longint c[4];
		longint acc;
		longint den;
		longint res;
		c[0] = (n - j) * (n - j) * (n - j);
		c[1] = 3 * j * j * j - 6 * j * j * n + 4 * n * n * n;
		c[2] = -3 * j * j * j + 3 * j * j * n + 3 * j * n * n + n * n * n;
		c[3] = j * j * j;
		den = 6 * n * n * n;
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			acc += c[k] * e[k];
		end
		res = floor_div(2 * acc + den, 2 * den);
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
		end
		if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
		end
		return res;
	endfunction

	function void push_sample(longint x, longint y, bit last_of_curve);
		cbpi_pkg::out_t s;
		s.curve_x = x[31:0];
		s.curve_y = y[31:0];
		s.run_end = 1'b0;
		s.curve_end = last_of_curve;
		samples_due.push_back(s);
	endfunction

	function void push_segment(longint ex[4], longint ey[4], int ins);
		longint n;
		n = ins + 1;
		for (longint j = 0; j < n; j++) begin
			push_sample(blend(ex, n, j), blend(ey, n, j), 1'b0);
		end
	endfunction

	function void note_point(cbpi_pkg::in_t it);
		longint px;
		longint py;
		longint ex[4];
		longint ey[4];
		int ins;
		int queued;
		cbpi_pkg::out_t s;
		px = longint'(it.point_x);
		py = longint'(it.point_y);
		ins = it.insert_count;
		queued = samples_due.size();
		if (ins > cbpi_pkg::MAX_INSERT) begin
			ins = cbpi_pkg::MAX_INSERT;
		end
		if (points_held >= 2) begin
			if (points_held == 3) begin
				ex[0] = hist_x[0];
				ey[0] = hist_y[0];
			end else begin
				ex[0] = 2 * hist_x[1] - hist_x[2];
				ey[0] = 2 * hist_y[1] - hist_y[2];
			end
			ex[1] = hist_x[1]; ey[1] = hist_y[1];
			ex[2] = hist_x[2]; ey[2] = hist_y[2];
			ex[3] = px; ey[3] = py;
			push_segment(ex, ey, held_counts[0]);
		end
		if (!it.final_point) begin
			hist_x[0] = hist_x[1]; hist_y[0] = hist_y[1];
			hist_x[1] = hist_x[2]; hist_y[1] = hist_y[2];
			hist_x[2] = px; hist_y[2] = py;
			held_counts[0] = held_counts[1];
			held_counts[1] = ins;
			if (points_held < 3) begin
				points_held++;
			end
		end else if (points_held == 0) begin
			push_sample(px, py, 1'b1);
		end else begin
			if (points_held == 1) begin
				ex[0] = 2 * hist_x[2] - px;
				ey[0] = 2 * hist_y[2] - py;
			end else begin
				ex[0] = hist_x[1];
				ey[0] = hist_y[1];
			end
			ex[1] = hist_x[2]; ey[1] = hist_y[2];
			ex[2] = px; ey[2] = py;
			ex[3] = 2 * px - hist_x[2];
			ey[3] = 2 * py - hist_y[2];
			push_segment(ex, ey, held_counts[1]);
			push_sample(blend(ex, 1, 1), blend(ey, 1, 1), 1'b1);
		end
		if (samples_due.size() > queued) begin
			s = samples_due.pop_back();
			s.run_end = 1'b1;
			samples_due.push_back(s);
		end
		if (it.final_point) begin
			clear_curve();
		end
	endfunction

	task report(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task check_sample(cbpi_pkg::out_t got);
		cbpi_pkg::out_t want;
		samples_checked++;
		if (samples_due.size() == 0) begin
			report($sformatf("unexpected sample x=%h y=%h", got.curve_x, got.curve_y));
		end else begin
			want = samples_due.pop_front();
			if (got.curve_x !== want.curve_x)
				report($sformatf("curve_x %h, expected %h", got.curve_x, want.curve_x));
			if (got.curve_y !== want.curve_y)
				report($sformatf("curve_y %h, expected %h", got.curve_y, want.curve_y));
			if (got.run_end !== want.run_end)
				report($sformatf("run_end %b, expected %b", got.run_end, want.run_end));
			if (got.curve_end !== want.curve_end)
				report($sformatf("curve_end %b, expected %b", got.curve_end, want.curve_end));
		end
	endtask
endclass

module tb_top;
	import cbpi_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_item;
	logic out_valid;
	logic out_ready;
	out_t out_item;

	int idle_pct;
	int stall_pct;
	int points_sent;
	int curves_sent;
	spline_scoreboard sb;

	cubic_bspline_point_inserter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			sb.check_sample(out_item);
		end
	end

	task send_point(logic signed [31:0] x, logic signed [31:0] y, logic [4:0] ins, logic fin);
		in_t it;
		it.point_x = x;
		it.point_y = y;
		it.insert_count = ins;
		it.final_point = fin;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_point(it);
		points_sent++;
		if (fin) begin
			curves_sent++;
		end
	endtask

	function logic signed [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(65535 * 4)) - 32'sd131072;
			3: return $signed(32'h7fff0000 + $urandom_range(65535));
			default: return $urandom;
		endcase
	endfunction

	function logic [4:0] pick_count();
		if ($urandom_range(9) == 0) begin
			return 5'($urandom_range(31));
		end
		return 5'($urandom_range(4));
	endfunction

	task send_curve(int len);
		for (int i = 0; i < len; i++) begin
			send_point(pick_coord(), pick_coord(), pick_count(), i == len - 1);
		end
	endtask

	task wait_drained();
		int guard;
		guard = 0;
		while (sb.samples_due.size() > 0 && guard < 500000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		points_sent = 0;
		curves_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single point curve; its count is ignored.
		send_point(32'sh00012345, -32'sh00010000, 5'd31, 1'b1);
		// Two point curve at opposite corners, so the mirrored nodes leave the coordinate range.
		send_point(32'sh7fffffff, 32'sh80000000, 5'd2, 1'b0);
		send_point(32'sh80000000, 32'sh7fffffff, 5'd0, 1'b1);
		// Longest segments, and a count above the limit.
		send_point(32'sh00000000, 32'sh00000000, 5'd30, 1'b0);
		send_point(32'sh00010000, 32'sh00020000, 5'd31, 1'b0);
		send_point(-32'sh00030000, 32'sh00005555, 5'd0, 1'b0);
		send_point(32'sh7fffffff, 32'sh7fffffff, 5'd1, 1'b0);
		send_point(32'sh80000000, 32'sh80000000, 5'd7, 1'b1);
		// Three point curve with all-ones and alternating bit patterns.
		send_point(32'shffffffff, 32'sh00000001, 5'd16, 1'b0);
		send_point(32'sh55555555, 32'shaaaaaaaa, 5'd8, 1'b0);
		send_point(32'shaaaaaaaa, 32'sh55555555, 5'd3, 1'b1);

		// Let the sender hold off until the block has fully drained.
		in_valid <= 1'b0;
		wait_drained();

		while (points_sent < 380) begin
			case ((points_sent / 95) % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 80; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 80; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			send_curve($urandom_range(9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 9));
		end
		in_valid <= 1'b0;
		stall_pct = 0;
		wait_drained();
		repeat (300) @(posedge clk);

		$display("Sent %0d control points in %0d curves, checked %0d curve samples.",
			points_sent, curves_sent, sb.samples_checked);
		$display("Covered idle and stall phases, coordinate extremes and saturating counts.");
		if (sb.errors == 0 && sb.samples_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (sb.samples_due.size() > 0) begin
				sb.report($sformatf("%0d samples never arrived", sb.samples_due.size()));
			end
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

/* filelist.f */
hw/rtl/cbpi_pkg.sv
hw/rtl/cbpi_weights.sv
hw/rtl/cbpi_mac.sv
hw/rtl/cbpi_div.sv
hw/rtl/cubic_bspline_point_inserter.sv
hw/rtl/cbpi_checker.sv
dv/tb_top.sv
